[hw/rtl/grb_pkg.sv]
// ----------------------------------------------------------------------------
// grb_pkg
// Shared widths, configuration codes and the exponential factor table for the
// Gaussian radial bump pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package grb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int SQ_W      = 2 * DATA_W;
  localparam int HALF_W    = 32;

  // The quotient has seven integer bits before it saturates at 64.0.
  localparam int INT_BITS  = 7;
  localparam int REM_W     = SQ_W + INT_BITS;
  localparam int NUM_Q     = INT_BITS + FRAC_BITS - 1;
  localparam int ARG_W     = NUM_Q + 1;
  localparam logic [ARG_W-1:0] ARG_MAX = ARG_W'(1) << NUM_Q;

  localparam int E_FRAC    = 62;
  localparam int E_W       = E_FRAC + 1;
  localparam int HI_W      = E_W - HALF_W;
  localparam int PROD_W    = 2 * E_W;
  localparam int SC_W      = DATA_W + E_W;
  localparam logic [E_W-1:0] E_ONE = E_W'(1) << E_FRAC;

  localparam int TAB_LOW   = 24;
  localparam int TAB_SIZE  = 31;
  localparam int TAB_OFS   = TAB_LOW - FRAC_BITS;

  localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = CFG_IDX_W'(0),
    REG_CENTER_Y   = CFG_IDX_W'(1),
    REG_SPREAD     = CFG_IDX_W'(2),
    REG_PEAK_VALUE = CFG_IDX_W'(3)
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] center_x;
    logic signed [DATA_W-1:0] center_y;
    logic        [SQ_W-1:0]   s2;
    logic signed [DATA_W-1:0] peak_value;
  } grb_cfg_t;

  typedef logic [TAB_SIZE-1:0][E_W-1:0] exp_tab_t;

  // Rounded Q1.62 product, evaluated only when the table is built.
  function automatic logic [E_W-1:0] mulr_f(input logic [E_W-1:0] a,
                                           input logic [E_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b) + (PROD_W'(1) << (E_FRAC - 1));
    return p[E_FRAC+E_W-1:E_FRAC];
  endfunction

  // Entry j holds exp(-2^(j-TAB_LOW)) in Q1.62. Small arguments use the
  // alternating Taylor sum, larger ones repeated squaring.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] x;
    logic [63:0] q;
    logic [7:0]  r;
    logic        done;
    int          m;
    int          k;
    int          b;
    tab = '0;
    for (m = 1; m <= TAB_LOW; m++) begin
      t    = 64'(1) << E_FRAC;
      s    = t;
      done = 1'b0;
      for (k = 1; k < 64; k++) begin
        if (!done) begin
          x = t >> m;
          q = '0;
          r = '0;
          for (b = 63; b >= 0; b--) begin
            r = {r[6:0], x[b]};
            if (r >= 8'(k)) begin
              r    = r - 8'(k);
              q[b] = 1'b1;
            end
          end
          t = q;
          if (t == '0) begin
            done = 1'b1;
          end else if (k[0]) begin
            s = s - t;
          end else begin
            s = s + t;
          end
        end
      end
      tab[TAB_LOW-m] = s[E_W-1:0];
    end
    for (k = TAB_LOW; k < TAB_SIZE; k++) begin
      tab[k] = mulr_f(tab[k-1], tab[k-1]);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

[hw/rtl/grb_dist.sv]
// ----------------------------------------------------------------------------
// grb_dist
// Three-stage squared distance: offsets from the center, squares, and a
// saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_dist (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [grb_pkg::DATA_W-1:0]  pos_x_i,
  input  logic signed [grb_pkg::DATA_W-1:0]  pos_y_i,
  input  grb_pkg::grb_cfg_t                  cfg_i,
  output logic                               valid_o,
  output logic        [grb_pkg::SQ_W-1:0]    d2_o
);
  import grb_pkg::*;

  logic              vld_q [3];
  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0] abs_x;
  logic [DIFF_W-1:0] abs_y;
  logic [DATA_W-1:0] mag_x_q;
  logic [DATA_W-1:0] mag_y_q;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]   sq_x_q;
  logic [SQ_W-1:0]   sq_y_q;
  logic [SQ_W:0]     sum;
  logic [SQ_W-1:0]   d2_q;

  assign dx    = {pos_x_i[DATA_W-1], pos_x_i} - {cfg_i.center_x[DATA_W-1], cfg_i.center_x};
  assign dy    = {pos_y_i[DATA_W-1], pos_y_i} - {cfg_i.center_y[DATA_W-1], cfg_i.center_y};
  assign abs_x = dx[DIFF_W-1] ? -dx : dx;
  assign abs_y = dy[DIFF_W-1] ? -dy : dy;

  // The offset of two 32-bit values never exceeds 2^32-1 in magnitude.
  assign sq_x = SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
  assign sq_y = SQ_W'(mag_y_q) * SQ_W'(mag_y_q);
  assign sum  = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vld_q[1] <= 1'b0;
      vld_q[2] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_x_q <= abs_x[DATA_W-1:0];
    mag_y_q <= abs_y[DATA_W-1:0];
    sq_x_q  <= sq_x;
    sq_y_q  <= sq_y;
    d2_q    <= sum[SQ_W] ? '1 : sum[SQ_W-1:0];
  end

  assign valid_o = vld_q[2];
  assign d2_o    = d2_q;

endmodule

`default_nettype wire

[hw/rtl/grb_div.sv]
// ----------------------------------------------------------------------------
// grb_div
// Pipelined restoring divider for the exponent argument d2 * 2^(F-1) / s2,
// one quotient bit per stage, with saturation at 64.0.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [grb_pkg::SQ_W-1:0]        d2_i,
  input  grb_pkg::grb_cfg_t               cfg_i,
  output logic                            valid_o,
  output logic [grb_pkg::ARG_W-1:0]       arg_o
);
  import grb_pkg::*;

  logic             vld_q [NUM_Q+1];
  logic             sat_q [NUM_Q+1];
  logic [NUM_Q-1:0] quo_q [NUM_Q+1];
  logic [REM_W-1:0] rem_q [NUM_Q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q[0] <= REM_W'(d2_i) >= {cfg_i.s2, {INT_BITS{1'b0}}};
    quo_q[0] <= '0;
    rem_q[0] <= REM_W'(d2_i);
  end

  for (genvar n = 1; n <= NUM_Q; n++) begin : g_stage
    logic             ge;
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] dvs;

    if (n <= INT_BITS) begin : g_int
      assign rem_in = rem_q[n-1];
      assign dvs    = REM_W'(cfg_i.s2) << (INT_BITS - n);
    end else begin : g_frac
      assign rem_in = rem_q[n-1] << 1;
      assign dvs    = REM_W'(cfg_i.s2);
    end

    assign ge = rem_in >= dvs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[n] <= 1'b0;
      end else begin
        vld_q[n] <= vld_q[n-1];
      end
    end

    always_ff @(posedge clk_i) begin
      sat_q[n] <= sat_q[n-1];
      quo_q[n] <= {quo_q[n-1][NUM_Q-2:0], ge};
    end

    if (n < NUM_Q) begin : g_rem
      logic [REM_W-1:0] diff;

      assign diff = rem_in - dvs;

      always_ff @(posedge clk_i) begin
        rem_q[n] <= ge ? diff : rem_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_Q];
  assign arg_o   = sat_q[NUM_Q] ? ARG_MAX : {1'b0, quo_q[NUM_Q]};

endmodule

`default_nettype wire

[hw/rtl/grb_exp_step.sv]
// ----------------------------------------------------------------------------
// grb_exp_step
// One bit of the exponential: multiplies the running Q1.62 value by a table
// factor when the selected argument bit is set. Two stages: partial products,
// then sum and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_exp_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          use_i,
  input  logic [grb_pkg::ARG_W-1:0]     arg_i,
  input  logic [grb_pkg::E_W-1:0]       e_i,
  input  logic [grb_pkg::E_W-1:0]       factor_i,
  output logic                          valid_o,
  output logic [grb_pkg::ARG_W-1:0]     arg_o,
  output logic [grb_pkg::E_W-1:0]       e_o
);
  import grb_pkg::*;

  logic                     vld_a_q;
  logic                     use_q;
  logic [ARG_W-1:0]         arg_a_q;
  logic [E_W-1:0]           e_a_q;
  logic [2*HALF_W-1:0]      pp_ll;
  logic [HALF_W+HI_W-1:0]   pp_lh;
  logic [HALF_W+HI_W-1:0]   pp_hl;
  logic [2*HI_W-1:0]        pp_hh;
  logic [2*HALF_W-1:0]      pp_ll_q;
  logic [HALF_W+HI_W-1:0]   pp_lh_q;
  logic [HALF_W+HI_W-1:0]   pp_hl_q;
  logic [2*HI_W-1:0]        pp_hh_q;
  logic [PROD_W-1:0]        sum;
  logic                     vld_b_q;
  logic [ARG_W-1:0]         arg_b_q;
  logic [E_W-1:0]           e_b_q;

  assign pp_ll = (2*HALF_W)'(e_i[HALF_W-1:0])
               * (2*HALF_W)'(factor_i[HALF_W-1:0]);
  assign pp_lh = (HALF_W+HI_W)'(e_i[HALF_W-1:0])
               * (HALF_W+HI_W)'(factor_i[E_W-1:HALF_W]);
  assign pp_hl = (HALF_W+HI_W)'(e_i[E_W-1:HALF_W])
               * (HALF_W+HI_W)'(factor_i[HALF_W-1:0]);
  assign pp_hh = (2*HI_W)'(e_i[E_W-1:HALF_W])
               * (2*HI_W)'(factor_i[E_W-1:HALF_W]);

  assign sum = {pp_hh_q, pp_ll_q}
             + (PROD_W'(pp_lh_q) << HALF_W)
             + (PROD_W'(pp_hl_q) << HALF_W)
             + (PROD_W'(1) << (E_FRAC - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    use_q   <= use_i;
    arg_a_q <= arg_i;
    e_a_q   <= e_i;
    pp_ll_q <= pp_ll;
    pp_lh_q <= pp_lh;
    pp_hl_q <= pp_hl;
    pp_hh_q <= pp_hh;
    arg_b_q <= arg_a_q;
    e_b_q   <= use_q ? sum[E_FRAC+E_W-1:E_FRAC] : e_a_q;
  end

  assign valid_o = vld_b_q;
  assign arg_o   = arg_b_q;
  assign e_o     = e_b_q;

endmodule

`default_nettype wire

[hw/rtl/grb_scale.sv]
// ----------------------------------------------------------------------------
// grb_scale
// Scales the falloff by the peak value with rounding half away from zero.
// The second stage is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [grb_pkg::E_W-1:0]           e_i,
  input  grb_pkg::grb_cfg_t                 cfg_i,
  output logic                              valid_o,
  output logic signed [grb_pkg::DATA_W-1:0] value_o
);
  import grb_pkg::*;

  logic                   neg;
  logic [DATA_W-1:0]      mag_pk;
  logic [2*HALF_W-1:0]    pp_lo;
  logic [DATA_W+HI_W-1:0] pp_hi;
  logic                   vld_a_q;
  logic                   neg_q;
  logic [2*HALF_W-1:0]    pp_lo_q;
  logic [DATA_W+HI_W-1:0] pp_hi_q;
  logic [SC_W-1:0]        sum;
  logic [DATA_W-1:0]      mag_r;
  logic                   vld_b_q;
  logic [DATA_W-1:0]      value_q;

  assign neg    = cfg_i.peak_value[DATA_W-1];
  assign mag_pk = neg ? -cfg_i.peak_value : cfg_i.peak_value;
  assign pp_lo  = (2*HALF_W)'(mag_pk) * (2*HALF_W)'(e_i[HALF_W-1:0]);
  assign pp_hi  = (DATA_W+HI_W)'(mag_pk) * (DATA_W+HI_W)'(e_i[E_W-1:HALF_W]);

  assign sum   = SC_W'(pp_lo_q) + (SC_W'(pp_hi_q) << HALF_W) + (SC_W'(1) << (E_FRAC - 1));
  assign mag_r = sum[E_FRAC+DATA_W-1:E_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg;
    pp_lo_q <= pp_lo;
    pp_hi_q <= pp_hi;
    value_q <= neg_q ? -mag_r : mag_r;
  end

  assign valid_o = vld_b_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

[hw/rtl/gaussian_radial_bump.sv]
// ----------------------------------------------------------------------------
// gaussian_radial_bump
// Two-dimensional Gaussian bump in signed Q16.16:
// peak_value * exp(-((x-cx)^2 + (y-cy)^2) / (2 * spread^2)).
// ----------------------------------------------------------------------------
// The block takes one point in every clock cycle and never raises busy. Each
// result leaves on value_out_o in Q16.16 with a one-cycle done_o strobe, in
// the order the points came in; the receiver cannot stall the pipeline. A
// point passes through the divider, which resolves one quotient bit per stage,
// and through the exponential, which spends a two-stage multiply on each
// argument bit. Registers are applied to every point in flight, so they
// should be written only while no point is in the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_radial_bump (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [grb_pkg::DATA_W-1:0]    pos_x_i,
  input  logic signed [grb_pkg::DATA_W-1:0]    pos_y_i,
  output logic                                 done_o,
  output logic signed [grb_pkg::DATA_W-1:0]    value_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [grb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [grb_pkg::DATA_W-1:0]    cfg_data_i
);
  import grb_pkg::*;

  logic [DATA_W-1:0] center_x_q;
  logic [DATA_W-1:0] center_y_q;
  logic [DATA_W-1:0] spread_q;
  logic [DATA_W-1:0] peak_q;
  logic [DATA_W-1:0] sigma;
  logic [SQ_W-1:0]   s2_q;
  grb_cfg_t          cfg;

  logic              dist_vld;
  logic [SQ_W-1:0]   dist_d2;
  logic              div_vld;
  logic [ARG_W-1:0]  div_arg;

  logic              exp_vld [ARG_W+1];
  logic [ARG_W-1:0]  exp_arg [ARG_W];
  logic [E_W-1:0]    exp_e   [ARG_W+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      spread_q   <= ONE_FIX;
      peak_q     <= ONE_FIX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CENTER_X:   center_x_q <= cfg_data_i;
        REG_CENTER_Y:   center_y_q <= cfg_data_i;
        REG_SPREAD:     spread_q   <= cfg_data_i;
        REG_PEAK_VALUE: peak_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero spread is taken as the smallest step.
  assign sigma = (spread_q == '0) ? DATA_W'(1) : spread_q;

  always_ff @(posedge clk_i) begin
    s2_q <= SQ_W'(sigma) * SQ_W'(sigma);
  end

  assign cfg.center_x   = center_x_q;
  assign cfg.center_y   = center_y_q;
  assign cfg.s2         = s2_q;
  assign cfg.peak_value = peak_q;

  grb_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .cfg_i   (cfg),
    .valid_o (dist_vld),
    .d2_o    (dist_d2)
  );

  grb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_vld),
    .d2_i    (dist_d2),
    .cfg_i   (cfg),
    .valid_o (div_vld),
    .arg_o   (div_arg)
  );

  assign exp_vld[0] = div_vld;
  assign exp_arg[0] = div_arg;
  assign exp_e[0]   = E_ONE;

  for (genvar i = 0; i < ARG_W; i++) begin : g_exp
    if (i < ARG_W - 1) begin : g_mid
      grb_exp_step u_step (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .valid_i  (exp_vld[i]),
        .use_i    (exp_arg[i][i]),
        .arg_i    (exp_arg[i]),
        .e_i      (exp_e[i]),
        .factor_i (EXP_TAB[i+TAB_OFS]),
        .valid_o  (exp_vld[i+1]),
        .arg_o    (exp_arg[i+1]),
        .e_o      (exp_e[i+1])
      );
    end else begin : g_last
      grb_exp_step u_step (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .valid_i  (exp_vld[i]),
        .use_i    (exp_arg[i][i]),
        .arg_i    (exp_arg[i]),
        .e_i      (exp_e[i]),
        .factor_i (EXP_TAB[i+TAB_OFS]),
        .valid_o  (exp_vld[i+1]),
        .arg_o    (),
        .e_o      (exp_e[i+1])
      );
    end
  end

  grb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exp_vld[ARG_W]),
    .e_i     (exp_e[ARG_W]),
    .cfg_i   (cfg),
    .valid_o (done_o),
    .value_o (value_out_o)
  );

endmodule

`default_nettype wire
